@@ rtl/chord_bass_note_picker_assert.svh @@
// ----------------------------------------------------------------------------
// chord_bass_note_picker assertion macros
// shared property forms for the checker, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef CHORD_BASS_NOTE_PICKER_ASSERT_SVH
`define CHORD_BASS_NOTE_PICKER_ASSERT_SVH

// same-cycle implication
`define CBNP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cbnp assertion failed");

// next-cycle implication
`define CBNP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cbnp assertion failed");

`endif

@@ rtl/cbnp_pkg.sv @@
// ----------------------------------------------------------------------------
// cbnp_pkg
// types, constants and helper functions of the chord bass note picker
// ----------------------------------------------------------------------------
`default_nettype none

package cbnp_pkg;

   localparam int unsigned MAX_CHANNELS_DEFAULT     = 16;
   localparam int unsigned CV_FRACTION_BITS_DEFAULT = 12;

   localparam int unsigned PITCH_W      = 17;
   localparam int unsigned NOTE_W       = 4;
   localparam int unsigned COUNT_W      = 5;
   localparam int unsigned OCT_W        = 4;
   localparam int unsigned OUT_CV_W     = 16;
   localparam int unsigned SCORE_W      = 8;
   localparam int unsigned LFSR_W       = 32;
   localparam int unsigned STORE_SEL_W  = 4;
   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 5;

   localparam int unsigned NOTES_PER_OCTAVE = 12;
   localparam int unsigned ROUND_OFFSET     = 6;
   localparam int unsigned MAX_BASE_OCTAVE  = 8;
   localparam int unsigned OCTAVE_BIAS      = 4;
   localparam int          OUT_CV_MAX       = 32767;
   localparam int          OUT_CV_MIN       = -32768;

   localparam logic [LFSR_W-1:0] LFSR_SEED = 32'hACE1ACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h80200003;

   localparam logic [1:0] MODE_HARMONIC = 2'd0;
   localparam logic [1:0] MODE_LOWEST   = 2'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PICK_MODE,
      CSR_MIN_VOICES,
      CSR_GATE_IN_USE,
      CSR_BASE_OCTAVE,
      CSR_REFERENCE_NOTE
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_HARMONIC,
      BK_LOWEST,
      BK_RANDOM_STEP,
      BK_RANDOM_SCALE,
      BK_RANDOM_READ,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [1:0]         pick_mode;
      logic [4:0]         min_voices;
      logic               gate_in_use;
      logic [3:0]         base_octave;
      logic [3:0]         reference_note;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pick_mode:      2'd0,
      min_voices:     5'd1,
      gate_in_use:    1'b0,
      base_octave:    4'd4,
      reference_note: 4'd0
   };

   typedef struct packed {
      logic                pick;
      logic [COUNT_W-1:0]  count;
   } job_ctrl_type;

   typedef struct packed {
      logic signed [PITCH_W-1:0] pitch_cv;
      logic                      gate_high;
      logic                      channel_present;
      logic                      frame_end;
   } req_payload_type;

   typedef struct packed {
      logic        [NOTE_W-1:0]   note_index;
      logic signed [OCT_W-1:0]    octave_offset;
      logic signed [OUT_CV_W-1:0] out_cv;
   } rsp_payload_type;

   // consonance penalty by interval in semitones
   function automatic logic [3:0] interval_score(input logic [3:0] interval);
      logic [3:0] score;
      unique case (interval)
         4'd0:    score = 4'd0;
         4'd1:    score = 4'd12;
         4'd2:    score = 4'd6;
         4'd3:    score = 4'd2;
         4'd4:    score = 4'd2;
         4'd5:    score = 4'd12;
         4'd6:    score = 4'd6;
         4'd7:    score = 4'd0;
         4'd8:    score = 4'd12;
         4'd9:    score = 4'd12;
         4'd10:   score = 4'd4;
         4'd11:   score = 4'd4;
         default: score = 4'd0;
      endcase
      return score;
   endfunction

   // cv of a semitone above the octave, rounded; only used on constants
   function automatic int unsigned note_cv_const(input int unsigned note,
                                                 input int unsigned frac_bits);
      return ((note << frac_bits) + ROUND_OFFSET) / NOTES_PER_OCTAVE;
   endfunction

endpackage

`default_nettype wire

@@ rtl/cbnp_stream_if.sv @@
// ----------------------------------------------------------------------------
// cbnp_stream_if
// valid/ready channel carrying one payload struct per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface cbnp_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/cbnp_queue.sv @@
// ----------------------------------------------------------------------------
// cbnp_queue
// short fifo of frame jobs between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module cbnp_queue #(
   parameter int unsigned WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import cbnp_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]  slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full     = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/cbnp_front.sv @@
// ----------------------------------------------------------------------------
// cbnp_front
// takes channel transactions, packs open channels, flags changes per frame
// ----------------------------------------------------------------------------
`default_nettype none

module cbnp_front #(
   parameter int unsigned MAX_CHANNELS     = cbnp_pkg::MAX_CHANNELS_DEFAULT,
   parameter int unsigned CV_FRACTION_BITS = cbnp_pkg::CV_FRACTION_BITS_DEFAULT
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  cbnp_pkg::cfg_type                                cfg,
   cbnp_stream_if.sink                                      req_bus,
   input  logic                                             queue_full,
   output logic                                             push,
   output cbnp_pkg::job_ctrl_type                           push_ctrl,
   output logic [MAX_CHANNELS-1:0][cbnp_pkg::NOTE_W-1:0]    push_notes,
   output logic [MAX_CHANNELS-1:0][cbnp_pkg::PITCH_W-1:0]   push_pitches
);
   import cbnp_pkg::*;

   localparam int unsigned IDX_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int unsigned SCALED_W = CV_FRACTION_BITS + 4;
   localparam logic [SCALED_W-1:0] HALF_STEP = SCALED_W'(1) << (CV_FRACTION_BITS - 1);

   logic [MAX_CHANNELS-1:0][PITCH_W-1:0] pitch_ff, pitch_in;
   logic [MAX_CHANNELS-1:0][NOTE_W-1:0]  note_ff, note_in;
   logic [MAX_CHANNELS-1:0]              gate_ff, gate_in;
   logic [COUNT_W-1:0]                   position_ff, position_in;
   logic [COUNT_W-1:0]                   count_ff, count_in;
   logic                                 change_ff, change_in;

   logic                       accept;
   logic                       gate_now;
   logic signed [PITCH_W-1:0]  cv;
   logic [SCALED_W-1:0]        scaled;
   logic [NOTE_W-1:0]          new_note;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign cv            = req_bus.payload.pitch_cv;
   assign gate_now      = cfg.gate_in_use & req_bus.payload.gate_high;

   // semitone within the octave from the fraction bits, may round up to 12
   assign scaled   = SCALED_W'(cv[CV_FRACTION_BITS-1:0]) * SCALED_W'(NOTES_PER_OCTAVE)
                   + HALF_STEP;
   assign new_note = scaled[CV_FRACTION_BITS +: NOTE_W];

   always_comb begin
      pitch_in    = pitch_ff;
      note_in     = note_ff;
      gate_in     = gate_ff;
      position_in = position_ff;
      count_in    = count_ff;
      change_in   = change_ff;
      push        = 1'b0;
      push_ctrl   = '0;
      if (accept) begin
         if (req_bus.payload.channel_present && (position_ff < COUNT_W'(MAX_CHANNELS))) begin
            if (gate_now != gate_ff[position_ff[IDX_W-1:0]]) begin
               change_in = 1'b1;
            end
            gate_in[position_ff[IDX_W-1:0]] = gate_now;
            if (gate_now || !cfg.gate_in_use) begin
               if (pitch_ff[count_ff[IDX_W-1:0]] != cv) begin
                  pitch_in[count_ff[IDX_W-1:0]] = cv;
                  note_in[count_ff[IDX_W-1:0]]  = new_note;
                  change_in = 1'b1;
               end
               count_in = count_ff + COUNT_W'(1);
            end
            position_in = position_ff + COUNT_W'(1);
         end
         if (req_bus.payload.frame_end) begin
            push            = 1'b1;
            push_ctrl.pick  = change_in && (count_in >= cfg.min_voices);
            push_ctrl.count = count_in;
            position_in     = '0;
            count_in        = '0;
            change_in       = 1'b0;
         end
      end
      push_notes   = note_in;
      push_pitches = pitch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff    <= '0;
         note_ff     <= '0;
         gate_ff     <= '0;
         position_ff <= '0;
         count_ff    <= '0;
         change_ff   <= 1'b0;
      end else begin
         pitch_ff    <= pitch_in;
         note_ff     <= note_in;
         gate_ff     <= gate_in;
         position_ff <= position_in;
         count_ff    <= count_in;
         change_ff   <= change_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/cbnp_back.sv @@
// ----------------------------------------------------------------------------
// cbnp_back
// runs the note pick of one frame job and drives the result register
// ----------------------------------------------------------------------------
`default_nettype none

module cbnp_back #(
   parameter int unsigned MAX_CHANNELS     = cbnp_pkg::MAX_CHANNELS_DEFAULT,
   parameter int unsigned CV_FRACTION_BITS = cbnp_pkg::CV_FRACTION_BITS_DEFAULT
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  cbnp_pkg::cfg_type                               cfg,
   input  logic                                            queue_empty,
   output logic                                            pop,
   input  cbnp_pkg::job_ctrl_type                          head_ctrl,
   input  logic [MAX_CHANNELS-1:0][cbnp_pkg::NOTE_W-1:0]   head_notes,
   input  logic [MAX_CHANNELS-1:0][cbnp_pkg::PITCH_W-1:0]  head_pitches,
   cbnp_stream_if.source                                   rsp_bus
);
   import cbnp_pkg::*;

   localparam int unsigned IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int unsigned NCV_W   = CV_FRACTION_BITS + 2;
   localparam int unsigned PROD_W  = LFSR_W + COUNT_W;
   localparam int unsigned NOTE_VALUES = 1 << NOTE_W;

   back_state_type state_ff, state_in;

   logic [MAX_CHANNELS-1:0][NOTE_W-1:0]  notes_i_ff, notes_i_in;
   logic [MAX_CHANNELS-1:0][NOTE_W-1:0]  notes_j_ff, notes_j_in;
   logic [MAX_CHANNELS-1:0][PITCH_W-1:0] pitch_ff, pitch_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]          i_ff, i_in;
   logic [IDX_W-1:0]          j_ff, j_in;
   logic [COUNT_W-1:0]        k_ff, k_in;
   logic [SCORE_W-1:0]        sum_ff, sum_in;
   logic [SCORE_W-1:0]        best_ff, best_in;
   logic signed [PITCH_W-1:0] low_pitch_ff, low_pitch_in;
   logic [NOTE_W-1:0]         low_note_ff, low_note_in;
   logic [NOTE_W-1:0]         held_ff, held_in;
   logic [LFSR_W-1:0]         lfsr_ff, lfsr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   logic [NCV_W-1:0]          note_cv_tab [NOTE_VALUES];

   logic [NOTE_W-1:0]         note_a, note_b;
   logic [NOTE_W:0]           interval_wide;
   logic [NOTE_W-1:0]         interval;
   logic [SCORE_W-1:0]        sum_total;
   logic                      last_i, last_j;
   logic [PROD_W-1:0]         product;
   logic [3:0]                knob;
   logic                      below_ref;
   logic signed [OCT_W:0]     oct_wide;
   logic signed [OCT_W-1:0]   octave;
   logic signed [31:0]        cv_wide;
   logic signed [OUT_CV_W-1:0] cv_sat;

   for (genvar n = 0; n < NOTE_VALUES; n++) begin : g_note_cv
      assign note_cv_tab[n] = NCV_W'(note_cv_const(n, CV_FRACTION_BITS));
   end

   // harmonic mode folds note 12 back to 0
   function automatic logic [NOTE_W-1:0] fold_note(input logic [NOTE_W-1:0] n);
      return (n == NOTE_W'(NOTES_PER_OCTAVE)) ? '0 : n;
   endfunction

   assign note_a = fold_note(notes_i_ff[i_ff]);
   assign note_b = fold_note(notes_j_ff[j_ff]);

   always_comb begin
      interval_wide = (NOTE_W + 1)'(note_b) + (NOTE_W + 1)'(NOTES_PER_OCTAVE)
                    - (NOTE_W + 1)'(note_a);
      if (interval_wide >= (NOTE_W + 1)'(NOTES_PER_OCTAVE)) begin
         interval_wide = interval_wide - (NOTE_W + 1)'(NOTES_PER_OCTAVE);
      end
      interval = interval_wide[NOTE_W-1:0];
   end

   assign sum_total = sum_ff + SCORE_W'(interval_score(interval));
   assign last_i    = (COUNT_W'(i_ff) + COUNT_W'(1)) == count_ff;
   assign last_j    = (COUNT_W'(j_ff) + COUNT_W'(1)) == count_ff;
   assign product   = PROD_W'(lfsr_ff) * PROD_W'(count_ff);

   // result fields from the held note
   assign knob      = (cfg.base_octave > 4'(MAX_BASE_OCTAVE)) ? 4'(MAX_BASE_OCTAVE)
                                                              : cfg.base_octave;
   assign below_ref = held_ff < cfg.reference_note;
   assign oct_wide  = signed'((OCT_W + 1)'(knob)) - signed'((OCT_W + 1)'(OCTAVE_BIAS))
                    + signed'((OCT_W + 1)'(below_ref));
   assign octave    = oct_wide[OCT_W-1:0];
   assign cv_wide   = (32'(octave) <<< CV_FRACTION_BITS) + signed'(32'(note_cv_tab[held_ff]));

   always_comb begin
      priority if (cv_wide > 32'(OUT_CV_MAX)) begin
         cv_sat = OUT_CV_W'(OUT_CV_MAX);
      end else if (cv_wide < 32'(OUT_CV_MIN)) begin
         cv_sat = OUT_CV_W'(OUT_CV_MIN);
      end else begin
         cv_sat = cv_wide[OUT_CV_W-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      notes_i_in     = notes_i_ff;
      notes_j_in     = notes_j_ff;
      pitch_in       = pitch_ff;
      count_in       = count_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      sum_in         = sum_ff;
      best_in        = best_ff;
      low_pitch_in   = low_pitch_ff;
      low_note_in    = low_note_ff;
      held_in        = held_ff;
      lfsr_in        = lfsr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      pop            = 1'b0;

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop        = 1'b1;
               notes_i_in = head_notes;
               notes_j_in = head_notes;
               pitch_in   = head_pitches;
               count_in   = head_ctrl.count;
               if (!head_ctrl.pick) begin
                  state_in = BK_EMIT;
               end else if (cfg.pick_mode == MODE_HARMONIC) begin
                  i_in     = '0;
                  j_in     = '0;
                  sum_in   = '0;
                  best_in  = '1;
                  state_in = (head_ctrl.count == '0) ? BK_EMIT : BK_HARMONIC;
               end else if (cfg.pick_mode == MODE_LOWEST) begin
                  low_pitch_in = signed'(head_pitches[0]);
                  low_note_in  = head_notes[0];
                  k_in         = COUNT_W'(1);
                  if (head_ctrl.count == '0) begin
                     held_in  = '0;
                     state_in = BK_EMIT;
                  end else begin
                     state_in = BK_LOWEST;
                  end
               end else begin
                  state_in = BK_RANDOM_STEP;
               end
            end
         end
         BK_HARMONIC: begin
            // one pair per cycle, score of note i closes at the last j
            if (last_j) begin
               if (sum_total < best_ff) begin
                  best_in = sum_total;
                  held_in = note_a;
               end
               sum_in = '0;
               j_in   = '0;
               if (last_i) begin
                  state_in = BK_EMIT;
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end else begin
               sum_in = sum_total;
               j_in   = j_ff + IDX_W'(1);
            end
         end
         BK_LOWEST: begin
            if (k_ff >= count_ff) begin
               held_in  = low_note_ff;
               state_in = BK_EMIT;
            end else begin
               if (signed'(pitch_ff[k_ff[IDX_W-1:0]]) < low_pitch_ff) begin
                  low_pitch_in = signed'(pitch_ff[k_ff[IDX_W-1:0]]);
                  low_note_in  = notes_i_ff[k_ff[IDX_W-1:0]];
               end
               k_in = k_ff + COUNT_W'(1);
            end
         end
         BK_RANDOM_STEP: begin
            lfsr_in  = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);
            state_in = BK_RANDOM_SCALE;
         end
         BK_RANDOM_SCALE: begin
            // channel index is the high word of lfsr times open count
            i_in     = IDX_W'(product[LFSR_W +: STORE_SEL_W]);
            state_in = BK_RANDOM_READ;
         end
         BK_RANDOM_READ: begin
            held_in  = notes_i_ff[i_ff];
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.note_index    = held_ff;
               rsp_payload_in.octave_offset = octave;
               rsp_payload_in.out_cv        = cv_sat;
               state_in                     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         held_ff      <= '0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      notes_i_ff     <= notes_i_in;
      notes_j_ff     <= notes_j_in;
      pitch_ff       <= pitch_in;
      count_ff       <= count_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      k_ff           <= k_in;
      sum_ff         <= sum_in;
      best_ff        <= best_in;
      low_pitch_ff   <= low_pitch_in;
      low_note_ff    <= low_note_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

endmodule

`default_nettype wire

@@ rtl/chord_bass_note_picker.sv @@
// flow: a frame-end transaction queues its job; the back part pops it, picks a note
//   (harmonic, lowest or random mode, or no pick) and registers the result
// throughput: one channel transaction per cycle while the job queue has room; the back
//   part scores harmonic pairs one pair a cycle and pops the next job only when idle
// reset: synchronous, active high; clears the pitch store, gates, config and
//   result valid flag, and loads the lfsr seed
// ----------------------------------------------------------------------------
// chord_bass_note_picker
// picks a bass note from a frame of pitch cv channels
// ----------------------------------------------------------------------------
`default_nettype none

module chord_bass_note_picker #(
   parameter int unsigned MAX_CHANNELS     = cbnp_pkg::MAX_CHANNELS_DEFAULT,
   parameter int unsigned CV_FRACTION_BITS = cbnp_pkg::CV_FRACTION_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [cbnp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cbnp_pkg::CSR_DATA_W-1:0]    csr_write_data,
   cbnp_stream_if.sink                        req_bus,
   cbnp_stream_if.source                      rsp_bus
);
   import cbnp_pkg::*;

   localparam int unsigned JOB_W = $bits(job_ctrl_type) + MAX_CHANNELS * (NOTE_W + PITCH_W);

   cfg_type cfg_ff, cfg_in;

   logic                                 push, pop, queue_full, queue_empty;
   job_ctrl_type                         push_ctrl, head_ctrl;
   logic [MAX_CHANNELS-1:0][NOTE_W-1:0]  push_notes, head_notes;
   logic [MAX_CHANNELS-1:0][PITCH_W-1:0] push_pitches, head_pitches;
   logic [JOB_W-1:0]                     push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PICK_MODE:      cfg_in.pick_mode      = csr_write_data[1:0];
            CSR_MIN_VOICES:     cfg_in.min_voices     = csr_write_data[4:0];
            CSR_GATE_IN_USE:    cfg_in.gate_in_use    = csr_write_data[0];
            CSR_BASE_OCTAVE:    cfg_in.base_octave    = csr_write_data[3:0];
            CSR_REFERENCE_NOTE: cfg_in.reference_note = csr_write_data[3:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbnp_front #(
      .MAX_CHANNELS     (MAX_CHANNELS),
      .CV_FRACTION_BITS (CV_FRACTION_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_bus      (req_bus),
      .queue_full   (queue_full),
      .push         (push),
      .push_ctrl    (push_ctrl),
      .push_notes   (push_notes),
      .push_pitches (push_pitches)
   );

   assign push_data = {push_ctrl, push_notes, push_pitches};
   assign {head_ctrl, head_notes, head_pitches} = pop_data;

   cbnp_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   cbnp_back #(
      .MAX_CHANNELS     (MAX_CHANNELS),
      .CV_FRACTION_BITS (CV_FRACTION_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .queue_empty  (queue_empty),
      .pop          (pop),
      .head_ctrl    (head_ctrl),
      .head_notes   (head_notes),
      .head_pitches (head_pitches),
      .rsp_bus      (rsp_bus)
   );

endmodule

`default_nettype wire

@@ rtl/cbnp_checker.sv @@
// ----------------------------------------------------------------------------
// cbnp_checker
// port-level checks of the chord bass note picker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "chord_bass_note_picker_assert.svh"

module cbnp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input cbnp_pkg::rsp_payload_type rsp_payload
);
   import cbnp_pkg::*;

   // a stalled result stays put
   `CBNP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // nothing pending and room for input right after reset
   `CBNP_ASSERT_NOW(a_rsp_clear_after_reset, $past(reset), !rsp_valid)
   `CBNP_ASSERT_NOW(a_req_open_after_reset, $past(reset), req_ready)

   // fields stay in their ranges
   `CBNP_ASSERT_NOW(a_rsp_range, rsp_valid,
      (rsp_payload.note_index <= 4'd12) && (rsp_payload.octave_offset <= 4'sd5) &&
      (rsp_payload.octave_offset >= -4'sd4))

   // root note at octave zero is zero volts
   `CBNP_ASSERT_NOW(a_rsp_zero_cv,
      rsp_valid && (rsp_payload.note_index == '0) && (rsp_payload.octave_offset == '0),
      rsp_payload.out_cv == '0)

endmodule

bind chord_bass_note_picker cbnp_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

`default_nettype wire
